// ===== src/cbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cbfp_pkg
// shared types and constants of the camera object-block frame parser
// ----------------------------------------------------------------------------
package cbfp_pkg;

    localparam int WORD_W  = 16;
    localparam int COUNT_W = 16;
    localparam int FIELD_W = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [WORD_W-1:0]  NO_WORD   = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [FIELD_W-1:0] LAST_FIELD = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_CC  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SIG  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SIG = 8'd3;

    localparam logic [WORD_W-1:0] RST_SYNC       = 16'hAA55;
    localparam logic [WORD_W-1:0] RST_SYNC_CC    = 16'hAA56;
    localparam logic [WORD_W-1:0] RST_FIRST_SIG  = 16'h0001;
    localparam logic [WORD_W-1:0] RST_SECOND_SIG = 16'h0002;

    typedef enum logic [1:0] {
        MODE_HUNT   = 2'd0,
        MODE_CHECK  = 2'd1,
        MODE_FIELDS = 2'd2,
        MODE_SEP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        TYPE_NONE   = 2'd0,
        TYPE_NORMAL = 2'd1,
        TYPE_CC     = 2'd2
    } t_frame_type;

    typedef struct packed {
        logic [WORD_W-1:0] sync_word;
        logic [WORD_W-1:0] sync_cc_word;
        logic [WORD_W-1:0] first_signature;
        logic [WORD_W-1:0] second_signature;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0] second_count;
        logic [COUNT_W-1:0] first_count;
        logic [COUNT_W-1:0] block_count;
        t_frame_type        frame_type;
        logic               frame_found;
    } t_result;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

// ===== src/cbfp_parser.sv =====
// ----------------------------------------------------------------------------
// cbfp_parser
// frame and block state machine with saturating block and signature counters
// ----------------------------------------------------------------------------
module cbfp_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [cbfp_pkg::WORD_W-1:0] i_word,
    input  cbfp_pkg::t_cfg             i_cfg,
    output logic                       o_emit,
    output cbfp_pkg::t_result          o_result
);
    import cbfp_pkg::*;

    t_mode              r_mode, n_mode;
    logic [WORD_W-1:0]  r_prev, n_prev;
    logic [FIELD_W-1:0] r_field, n_field;
    logic [COUNT_W-1:0] r_blocks, n_blocks;
    logic [COUNT_W-1:0] r_first, n_first;
    logic [COUNT_W-1:0] r_second, n_second;
    t_frame_type        r_type, n_type;
    logic               r_found, n_found;

    logic is_sync, is_sync_cc, is_zero, zero_pair, sync_pair, is_start;

    assign is_sync    = (i_word == i_cfg.sync_word);
    assign is_sync_cc = (i_word == i_cfg.sync_cc_word);
    assign is_zero    = (i_word == '0);
    assign is_start   = is_sync || is_sync_cc;
    assign zero_pair  = is_zero && (r_prev == '0);
    assign sync_pair  = (r_prev == i_cfg.sync_word) && is_start;

    // next state
    always_comb begin
        n_mode = r_mode;
        if (i_step) begin
            unique case (r_mode)
                MODE_HUNT: begin
                    if (!zero_pair && sync_pair) begin
                        n_mode = MODE_CHECK;
                    end
                end
                MODE_CHECK: begin
                    n_mode = (is_start || is_zero) ? MODE_HUNT : MODE_FIELDS;
                end
                MODE_FIELDS: begin
                    if (r_field >= LAST_FIELD) begin
                        n_mode = MODE_SEP;
                    end
                end
                MODE_SEP: begin
                    n_mode = is_start ? MODE_CHECK : MODE_HUNT;
                end
                default: n_mode = MODE_HUNT;
            endcase
        end
    end

    // datapath and outputs
    always_comb begin
        n_prev   = r_prev;
        n_field  = r_field;
        n_blocks = r_blocks;
        n_first  = r_first;
        n_second = r_second;
        n_type   = r_type;
        n_found  = r_found;
        o_emit   = 1'b0;
        if (i_step) begin
            unique case (r_mode)
                MODE_HUNT: begin
                    if (zero_pair) begin
                        // idle zeros end the run with empty counts
                        n_found  = 1'b0;
                        n_blocks = '0;
                        n_first  = '0;
                        n_second = '0;
                        o_emit   = 1'b1;
                        n_prev   = NO_WORD;
                        n_field  = '0;
                    end else if (sync_pair) begin
                        n_type   = is_sync ? TYPE_NORMAL : TYPE_CC;
                        n_found  = 1'b1;
                        n_blocks = '0;
                        n_first  = '0;
                        n_second = '0;
                    end else begin
                        n_prev = i_word;
                    end
                end
                MODE_CHECK: begin
                    if (is_start || is_zero) begin
                        o_emit  = 1'b1;
                        n_prev  = NO_WORD;
                        n_field = '0;
                    end else begin
                        n_blocks = sat_inc(r_blocks);
                        n_field  = '0;
                    end
                end
                MODE_FIELDS: begin
                    if (r_field == '0) begin
                        priority if (i_word == i_cfg.first_signature) begin
                            n_first = sat_inc(r_first);
                        end else if (i_word == i_cfg.second_signature) begin
                            n_second = sat_inc(r_second);
                        end
                    end
                    n_field = (r_field >= LAST_FIELD) ? '0 : r_field + 1'b1;
                end
                MODE_SEP: begin
                    if (!is_start) begin
                        o_emit  = 1'b1;
                        n_prev  = NO_WORD;
                        n_field = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // the result carries the counts as they stand after this word
    assign o_result.frame_found  = n_found;
    assign o_result.frame_type   = r_type;
    assign o_result.block_count  = n_blocks;
    assign o_result.first_count  = n_first;
    assign o_result.second_count = n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_HUNT;
            r_prev   <= NO_WORD;
            r_field  <= '0;
            r_blocks <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_type   <= TYPE_NONE;
            r_found  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_prev   <= n_prev;
            r_field  <= n_field;
            r_blocks <= n_blocks;
            r_first  <= n_first;
            r_second <= n_second;
            r_type   <= n_type;
            r_found  <= n_found;
        end
    end

`ifndef SYNTHESIS
    a_emit_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_mode == MODE_HUNT && r_prev == NO_WORD && r_field == '0))
        else $error("parser did not return to hunt after a result");

    a_no_emit_in_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (r_mode != MODE_FIELDS))
        else $error("result raised inside block fields");

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field <= LAST_FIELD)
        else $error("field index out of range");

    a_class_le_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first <= r_blocks) && (r_second <= r_blocks))
        else $error("class count above block count");

    a_idle_result_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && !o_result.frame_found) |->
            (o_result.block_count == '0 && o_result.first_count == '0
             && o_result.second_count == '0))
        else $error("idle-zero result with nonzero counts");
`endif

endmodule

// ===== src/camera_block_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// camera_block_frame_parser_top
// object-block frame parser for a 16-bit camera word stream
// ----------------------------------------------------------------------------
// Takes one word per cycle while results are taken: a word is registered, run
// through the parser state machine once the output register is free, and any
// run summary is written to the output register at the end of that cycle. The
// only stall comes from the output register: while it holds a result that is
// not taken, the input register fills and tready drops. A result is produced
// when a run ends (two zero words while hunting, a sync, colour-code sync or
// zero word in a checksum slot, or a non-sync separator). tdata carries
// block_count, first_count, second_count from bit 0 up; tuser carries
// frame_found in bit 0 and frame_type in bits 2:1. Configuration writes take
// effect on the next cycle and are to be made while the block is idle.
module camera_block_frame_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // data_word [15:0]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,
    // block_count [15:0], first_count [31:16], second_count [47:32]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,
    // frame_found [0], frame_type [2:1]
    output logic [2:0]                    m_axis_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbfp_pkg::WORD_W-1:0]   i_cfg_data
);
    import cbfp_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_word;
    logic              r_out_valid;
    t_result           r_out;

    logic    s_accept, advance, emit;
    t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_word        <= RST_SYNC;
            r_cfg.sync_cc_word     <= RST_SYNC_CC;
            r_cfg.first_signature  <= RST_FIRST_SIG;
            r_cfg.second_signature <= RST_SECOND_SIG;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC:       r_cfg.sync_word        <= i_cfg_data;
                CFG_SYNC_CC:    r_cfg.sync_cc_word     <= i_cfg_data;
                CFG_FIRST_SIG:  r_cfg.first_signature  <= i_cfg_data;
                CFG_SECOND_SIG: r_cfg.second_signature <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage moves on whenever the output register can take a result
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_word <= s_axis_tdata;
        end
    end

    cbfp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_word   (r_in_word),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.second_count, r_out.first_count, r_out.block_count};
    assign m_axis_tuser  = {r_out.frame_type, r_out.frame_found};

endmodule

// ===== tb/cbfp_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbfp_frame_checker
// watches the parser channels, predicts each run summary and compares
// ----------------------------------------------------------------------------
// Follows every accepted word and register write with its own copy of the
// parser state. A run summary is queued whenever a word closes a run. Each
// summary leaving the block is checked field by field against the oldest one.
module cbfp_frame_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [15:0]                    i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [47:0]                    i_m_tdata,
    input  logic [2:0]                     i_m_tuser,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [cbfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbfp_pkg::WORD_W-1:0]    i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import cbfp_pkg::*;

    logic [WORD_W-1:0]  reg_sync, reg_sync_cc, reg_sig1, reg_sig2;
    t_mode              mode;
    logic [WORD_W-1:0]  prev_word;
    logic [FIELD_W-1:0] field_idx;
    logic [COUNT_W-1:0] blocks, hits1, hits2;
    t_frame_type        last_type;
    logic               found;

    t_result            run_summary_q [$];
    int                 mismatches;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void close_run();
        t_result summary;
        summary.frame_found  = found;
        summary.frame_type   = last_type;
        summary.block_count  = blocks;
        summary.first_count  = hits1;
        summary.second_count = hits2;
        run_summary_q.push_back(summary);
        mode      = MODE_HUNT;
        prev_word = 16'hFFFF;
        field_idx = '0;
    endfunction

    function automatic void clear_counts();
        blocks = '0;
        hits1  = '0;
        hits2  = '0;
    endfunction

    function automatic void track_word(input logic [WORD_W-1:0] w);
        case (mode)
            MODE_HUNT: begin
                // zero pair is tested first, so it wins over a zero sync word
                if (w == 16'h0000 && prev_word == 16'h0000) begin
                    found = 1'b0;
                    clear_counts();
                    close_run();
                end else if (prev_word == reg_sync && (w == reg_sync || w == reg_sync_cc)) begin
                    last_type = (w == reg_sync) ? TYPE_NORMAL : TYPE_CC;
                    found     = 1'b1;
                    clear_counts();
                    mode      = MODE_CHECK;
                end else begin
                    prev_word = w;
                end
            end
            MODE_CHECK: begin
                if (w == reg_sync || w == reg_sync_cc || w == 16'h0000) begin
                    close_run();
                end else begin
                    blocks    = bump(blocks);
                    field_idx = '0;
                    mode      = MODE_FIELDS;
                end
            end
            MODE_FIELDS: begin
                if (field_idx == '0) begin
                    if (w == reg_sig1)
                        hits1 = bump(hits1);
                    else if (w == reg_sig2)
                        hits2 = bump(hits2);
                end
                if (field_idx >= LAST_FIELD) begin
                    field_idx = '0;
                    mode      = MODE_SEP;
                end else begin
                    field_idx = field_idx + 3'd1;
                end
            end
            default: begin
                if (w == reg_sync || w == reg_sync_cc)
                    mode = MODE_CHECK;
                else
                    close_run();
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            reg_sync    = RST_SYNC;
            reg_sync_cc = RST_SYNC_CC;
            reg_sig1    = RST_FIRST_SIG;
            reg_sig2    = RST_SECOND_SIG;
            mode        = MODE_HUNT;
            prev_word   = 16'hFFFF;
            field_idx   = '0;
            clear_counts();
            last_type   = TYPE_NONE;
            found       = 1'b0;
            run_summary_q.delete();
            mismatches  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SYNC:       reg_sync    = i_cfg_data;
                    CFG_SYNC_CC:    reg_sync_cc = i_cfg_data;
                    CFG_FIRST_SIG:  reg_sig1    = i_cfg_data;
                    CFG_SECOND_SIG: reg_sig2    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                track_word(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (run_summary_q.size() == 0) begin
                    $display("%0t: unexpected run summary, expected none actual tdata %h tuser %h",
                             $time, i_m_tdata, i_m_tuser);
                    mismatches++;
                end else begin
                    want = run_summary_q.pop_front();
                    check_field("frame_found", 16'(want.frame_found), 16'(i_m_tuser[0]));
                    check_field("frame_type", 16'(want.frame_type), 16'(i_m_tuser[2:1]));
                    check_field("block_count", want.block_count, i_m_tdata[15:0]);
                    check_field("first_count", want.first_count, i_m_tdata[31:16]);
                    check_field("second_count", want.second_count, i_m_tdata[47:32]);
                end
            end
        end
        o_pending    <= run_summary_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_camera_block_frame_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_camera_block_frame_parser_top
// stimulus and verdict for the camera object-block frame parser
// ----------------------------------------------------------------------------
// Drives a short directed word sequence, then random frames of sync pairs,
// blocks and terminators mixed with noise and cut-off frames, under several
// register settings. The sender idles in bursts, the receiver stalls on its
// own pattern; the checker beside the block does all prediction and
// comparison.
module tb_camera_block_frame_parser_top;
    import cbfp_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    int fail_count;
    int pending_results;

    // stimulus-side view of the current register settings
    logic [15:0] cur_sync = RST_SYNC;
    logic [15:0] cur_sync_cc = RST_SYNC_CC;
    logic [15:0] cur_sig1 = RST_FIRST_SIG;
    logic [15:0] cur_sig2 = RST_SECOND_SIG;

    int burst_left = 0;
    int words_sent = 0;
    int stall_cycle = 0;
    int stall_phase = 0;

    always #10 i_clk = ~i_clk;

    camera_block_frame_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    cbfp_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // receiver: stalls on one of four patterns, drawn anew at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            stall_cycle++;
            if (stall_cycle % 64 == 0)
                stall_phase = $urandom_range(0, 3);
            case (stall_phase)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= (stall_cycle % 64 >= 40);
            endcase
        end
    end

    task automatic send_word(input logic [15:0] w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 16'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return cur_sync;
            3: return cur_sync_cc;
            4: return cur_sig1;
            5: return cur_sig2;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sig();
        case ($urandom_range(0, 4))
            0, 1: return cur_sig1;
            2: return cur_sig2;
            3: return pick_word();
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sync();
        return $urandom_range(0, 1) ? cur_sync : cur_sync_cc;
    endfunction

    function automatic logic [15:0] pick_bad_checksum();
        case ($urandom_range(0, 2))
            0: return cur_sync;
            1: return cur_sync_cc;
            default: return 16'h0000;
        endcase
    endfunction

    // one frame, a zero pair, or a little noise
    task automatic send_frame();
        int kind;
        int nblk;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            send_word(16'h0000);
            send_word(16'h0000);
        end else if (kind < 18) begin
            n = $urandom_range(1, 6);
            repeat (n) send_word(pick_word());
        end else begin
            // a lone sync only starts a frame when it pairs with the hunt start value
            send_word(cur_sync);
            if ($urandom_range(0, 4) != 0)
                send_word(pick_sync());
            nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            for (int b = 0; b < nblk; b++) begin
                if (b != 0)
                    send_word(pick_sync());
                if ($urandom_range(0, 15) == 0)
                    send_word(pick_word());
                else
                    send_word(16'($urandom_range(1, 16'hFFFF)));
                send_word(pick_sig());
                repeat (4) send_word(pick_word());
                // cut-off frame: the next words land mid-frame
                if ($urandom_range(0, 39) == 0)
                    return;
            end
            if (nblk == 0) begin
                send_word(pick_bad_checksum());
            end else if ($urandom_range(0, 1)) begin
                send_word(pick_sync());
                send_word(pick_bad_checksum());
            end else begin
                send_word($urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom));
            end
        end
    endtask

    task automatic random_frames(input int n);
        int target;
        target = words_sent + n;
        while (words_sent < target)
            send_frame();
    endtask

    // sender stops until every run summary is out and the pipeline is empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] sync_w, input logic [15:0] sync_cc_w,
                              input logic [15:0] sig1, input logic [15:0] sig2);
        write_reg(CFG_SYNC, sync_w);
        write_reg(CFG_SYNC_CC, sync_cc_w);
        write_reg(CFG_FIRST_SIG, sig1);
        write_reg(CFG_SECOND_SIG, sig2);
        // index past the register list, must change nothing
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), 16'($urandom));
        i_cfg_valid <= 1'b0;
        cur_sync    = sync_w;
        cur_sync_cc = sync_cc_w;
        cur_sig1    = sig1;
        cur_sig2    = sig2;
    endtask

    initial begin
        logic [15:0] directed_words [$];
        logic [15:0] v;
        logic [15:0] u;
        directed_words = {
            16'h0000, 16'h0000,
            16'hAA55, 16'hAA55, 16'h1234, 16'h0001, 16'hAA55, 16'h0000, 16'hFFFF, 16'hAA56,
            16'hAA56, 16'hFFFF, 16'h0002, 16'h0000, 16'hAA56, 16'h8000, 16'h7FFF, 16'h7FFF,
            16'hAA55, 16'hAA56, 16'h0000,
            16'h0000, 16'h0000,
            16'hAA55, 16'hAA55, 16'hAA56
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[k])
            send_word(directed_words[k]);
        random_frames(400);

        // zero sync word, extreme signatures
        wait_idle();
        set_config(16'h0000, 16'($urandom), 16'h0000, 16'hFFFF);
        random_frames(250);

        // all-ones sync word: a single sync opens a frame at the start of a hunt
        wait_idle();
        set_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        random_frames(250);

        // equal sync words and equal signatures
        wait_idle();
        v = 16'($urandom);
        u = 16'($urandom_range(0, 3));
        set_config(v, v, u, u);
        random_frames(250);

        wait_idle();
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        random_frames(350);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("** camera_block_frame_parser_top: PASSED **");
        else
            $display("** camera_block_frame_parser_top: FAILED **");
        $finish;
    end

    initial begin
        #(64'd80_000_000);
        $display("** camera_block_frame_parser_top: FAILED **");
        $finish;
    end

endmodule
